// ===== rtl/sirq_pkg.sv =====
// ----------------------------------------------------------------------------
// sirq_pkg: shared types for the sorted insert ring queue
// Command, status and state codes, request/result words, stored entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sirq_pkg;

	// result occupancy field width (count is masked to this)
	localparam int OCC_W = 5;

	typedef enum logic [1:0] {
		CMD_PUSH        = 2'd0,
		CMD_SORTED_PUSH = 2'd1,
		CMD_POP         = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_INSERT,
		ST_POP
	} state_t;

	// input word
	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] item_value;
		logic signed [31:0] item_key;
	} request_t;

	// output word
	typedef struct packed {
		logic signed [31:0] popped_value;
		logic [1:0]         status;
		logic [OCC_W-1:0]   occupancy;
	} result_t;

	// one queue slot
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] key;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_insert_ring_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_ring_queue_top: ring queue with plain push, sorted push, pop
// Plain push, overflow, underflow, unused code: result formed at accept;
// pop reads the head, then returns it; sorted push shifts one entry per step
// until a stored key is not above it or all held entries moved, then inserts.
// One slot per cycle through one key comparator; busy is high meanwhile and
// the next word is taken at the edge that takes done. Reset clears pointers,
// count and sequencer, not entry contents; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_ring_queue_top
	import sirq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire request_t request,
	output logic          busy,
	output logic          done,
	output result_t       result
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          emit;
	result_t       res;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	entry_t        mem_rdata;
	logic          done_q;
	result_t       result_q;

	sirq_ctrl #(
		.DEPTH (QUEUE_DEPTH),
		.IW    (IW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.emit      (emit),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sirq_mem #(
		.DEPTH (QUEUE_DEPTH),
		.IW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/sirq_mem.sv =====
// ----------------------------------------------------------------------------
// sirq_mem: entry storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sirq_mem
	import sirq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [IW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic          re,
	input  wire logic [IW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sirq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sirq_ctrl: queue sequencer
// Holds head, tail and count; walks back from the rear one slot per cycle
// through a single key comparator for sorted push.
// ----------------------------------------------------------------------------
`default_nettype none

module sirq_ctrl
	import sirq_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IW    = 4,
	parameter int CW    = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire request_t      request,
	output logic               busy,
	output logic               emit,
	output result_t            res,
	// storage port
	output logic               mem_we,
	output logic [IW-1:0]      mem_waddr,
	output entry_t             mem_wdata,
	output logic               mem_re,
	output logic [IW-1:0]      mem_raddr,
	input  wire entry_t        mem_rdata
);

	function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] i);
		return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
	endfunction

	state_t         state_q, state_d;
	logic [IW-1:0]  head_q, head_d;
	logic [IW-1:0]  tail_q, tail_d;
	logic [CW-1:0]  count_q, count_d;
	logic [IW-1:0]  ins_q, ins_d;
	logic [CW-1:0]  moved_q, moved_d;
	request_t       req_q;

	logic           full;
	logic           key_gt;
	logic [IW-1:0]  ins_prev;
	logic [CW-1:0]  moved_nx;

	assign full     = (count_q == CW'(DEPTH));
	assign ins_prev = slot_prev(ins_q);
	assign moved_nx = moved_q + 1'b1;
	// the shared comparator: stored key strictly above the new key
	assign key_gt   = ($signed(mem_rdata.key) > $signed(req_q.item_key));
	assign busy     = (state_q != ST_IDLE);

	// state and pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ins_q   <= '0;
			moved_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			ins_q   <= ins_d;
			moved_q <= moved_d;
		end
	end

	// latched command word
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request;
		end
	end

	// next state, storage access and result
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		ins_d     = ins_q;
		moved_d   = moved_q;
		mem_we    = 1'b0;
		mem_waddr = ins_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = ins_prev;
		emit      = 1'b0;
		res.popped_value = '0;
		res.status       = STATUS_OK;
		res.occupancy    = OCC_W'(count_q);

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (request.command == CMD_PUSH || request.command == CMD_SORTED_PUSH) begin
						if (full) begin
							emit       = 1'b1;
							res.status = STATUS_OVERFLOW;
						end else if (request.command == CMD_PUSH || count_q == '0) begin
							// append at the rear right away
							mem_we          = 1'b1;
							mem_waddr       = tail_q;
							mem_wdata.value = request.item_value;
							mem_wdata.key   = (request.command == CMD_PUSH) ?
							                  request.item_value : request.item_key;
							tail_d          = slot_next(tail_q);
							count_d         = count_q + 1'b1;
							emit            = 1'b1;
							res.occupancy   = OCC_W'(count_d);
						end else begin
							// start the walk at the slot before the rear
							mem_re    = 1'b1;
							mem_raddr = slot_prev(tail_q);
							ins_d     = tail_q;
							moved_d   = '0;
							state_d   = ST_SHIFT;
						end
					end else if (request.command == CMD_POP) begin
						if (count_q == '0) begin
							emit       = 1'b1;
							res.status = STATUS_UNDERFLOW;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = head_q;
							state_d   = ST_POP;
						end
					end else begin
						// unused code: no change
						emit = 1'b1;
					end
				end
			end

			ST_SHIFT: begin
				// read data holds the entry just before ins_q
				if (key_gt) begin
					mem_we    = 1'b1;
					mem_waddr = ins_q;
					mem_wdata = mem_rdata;
					ins_d     = ins_prev;
					moved_d   = moved_nx;
					if (moved_nx < count_q) begin
						mem_re    = 1'b1;
						mem_raddr = slot_prev(ins_prev);
					end else begin
						state_d = ST_INSERT;
					end
				end else begin
					state_d = ST_INSERT;
				end
			end

			ST_INSERT: begin
				mem_we          = 1'b1;
				mem_waddr       = ins_q;
				mem_wdata.value = req_q.item_value;
				mem_wdata.key   = req_q.item_key;
				tail_d          = slot_next(tail_q);
				count_d         = count_q + 1'b1;
				emit            = 1'b1;
				res.occupancy   = OCC_W'(count_d);
				state_d         = ST_IDLE;
			end

			ST_POP: begin
				head_d           = slot_next(head_q);
				count_d          = count_q - 1'b1;
				emit             = 1'b1;
				res.popped_value = mem_rdata.value;
				res.occupancy    = OCC_W'(count_d);
				state_d          = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sirq_checker.sv =====
// ----------------------------------------------------------------------------
// sirq_checker: port-level checks for the sorted insert ring queue
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sirq_checker
	import sirq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     done,
	input wire result_t  result
);

	// busy only follows an accepted command
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// a result word is never shown while a command is still in work
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// underflow leaves an empty queue and no data
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STATUS_UNDERFLOW) |->
		(result.occupancy == '0 && result.popped_value == '0))
		else $error("bad underflow word");

	// overflow only at full depth
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STATUS_OVERFLOW) |->
		(result.occupancy == OCC_W'(QUEUE_DEPTH) && result.popped_value == '0))
		else $error("bad overflow word");

endmodule

bind sorted_insert_ring_queue_top sirq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_sirq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

`default_nettype wire
